>>> design/wrsi_pkg.sv
// Package with the types and constants of the Wilder RSI tracker.
`default_nettype none
package wrsi_pkg;
   localparam int PRICE_BITS            = 32;
   localparam int AVG_BITS              = 48;
   localparam int COUNT_BITS            = 9;
   localparam int PERIOD_BITS           = 8;
   localparam int RSI_BITS              = 14;
   localparam int SMOOTH_BITS           = 64;
   localparam int DEFAULT_FRACTION_BITS = 16;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MIN   = 8'd2;
   localparam logic [RSI_BITS-1:0]    RSI_FULL     = 14'd10000;

   typedef struct packed {
      logic [PRICE_BITS-1:0] price;
      logic                  series_start;
   } req_word_type;

   typedef struct packed {
      logic [RSI_BITS-1:0] rsi_hundredths;
      logic                ready_res;
   } rsp_word_type;
endpackage
`default_nettype wire

>>> design/wilder_rsi_tracker_unit.sv
// Top level of the Wilder RSI tracker with its sequencer and state.
//
// Usage: each word on the req_ channel carries one price sample and a
// series_start flag. A word with series_start set stores the price, clears
// the averages and yields a result with ready_res 0. Other words form a
// price change; the first smoothing_period changes are summed and then
// divided to seed the averages, and every later change smooths them.
// Each accepted word yields exactly one rsp_ word. A seeded word runs two
// average divisions and one ratio division through one shared restoring
// divider that retires one quotient bit per cycle; the ratio division is
// skipped when the average loss is zero. A word that only adds to the seed
// sum, or starts a series, runs no division. One word is processed at a
// time; req_stall is high meanwhile.
// The result sits in an output register; a stalled rsp_ word holds and the
// next word waits until it is taken. Reset clears the state and sets the
// period register to 14. The csr_ port writes the period; the user is to
// use it only while idle, as the block itself does not enforce it.
`default_nettype none
module wilder_rsi_tracker_unit import wrsi_pkg::*; #(
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_word_type     req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_word_type          rsp_word,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [PERIOD_BITS-1:0] csr_data
);
   localparam int DVD_BITS = (AVG_BITS + FRACTION_BITS > SMOOTH_BITS) ?
                             AVG_BITS + FRACTION_BITS : SMOOTH_BITS;
   localparam int DVS_BITS = AVG_BITS + 1;
   localparam logic [AVG_BITS-1:0]   AVG_MAX     = '1;
   localparam logic [COUNT_BITS-1:0] SEEDED_MARK = COUNT_BITS'(1) << (COUNT_BITS - 1);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_GO_GAIN   = 8'b0000_0010,
      S_WAIT_GAIN = 8'b0000_0100,
      S_GO_LOSS   = 8'b0000_1000,
      S_WAIT_LOSS = 8'b0001_0000,
      S_GO_RSI    = 8'b0010_0000,
      S_WAIT_RSI  = 8'b0100_0000,
      S_RESULT    = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PERIOD_BITS-1:0] p_ff, p_in;
   logic [PRICE_BITS-1:0]  prev_ff, prev_in;
   logic [AVG_BITS-1:0]    gain_ff, gain_in;
   logic [AVG_BITS-1:0]    loss_ff, loss_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [PRICE_BITS-1:0]  xg_ff, xg_in;
   logic [PRICE_BITS-1:0]  xl_ff, xl_in;
   logic                   seed_ff, seed_in;
   rsp_word_type           res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   accept;
   logic [PERIOD_BITS-1:0] p_now;
   logic [PRICE_BITS-1:0]  dg, dl;
   logic [AVG_BITS:0]      sum_g, sum_l;
   logic [AVG_BITS-1:0]    sat_g, sat_l;
   logic [COUNT_BITS-1:0]  count_nx;
   logic [AVG_BITS-1:0]    avg_sel;
   logic [PRICE_BITS-1:0]  x_sel;
   logic [SMOOTH_BITS-1:0] smooth_dvd;
   logic [AVG_BITS+RSI_BITS-1:0] scaled;
   logic                   div_start;
   logic [DVD_BITS-1:0]    div_dvd;
   logic [DVS_BITS-1:0]    div_dvs;
   logic                   div_done;
   logic [DVD_BITS-1:0]    div_quo;
   logic [AVG_BITS-1:0]    quo_sat;

   wrsi_divider #(
      .DVD_BITS (DVD_BITS),
      .DVS_BITS (DVS_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      p_now    = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;
      dg       = (req_word.price > prev_ff) ? req_word.price - prev_ff : '0;
      dl       = (req_word.price > prev_ff) ? '0 : prev_ff - req_word.price;
      sum_g    = {1'b0, gain_ff} + (AVG_BITS+1)'(dg);
      sum_l    = {1'b0, loss_ff} + (AVG_BITS+1)'(dl);
      sat_g    = sum_g[AVG_BITS] ? AVG_MAX : sum_g[AVG_BITS-1:0];
      sat_l    = sum_l[AVG_BITS] ? AVG_MAX : sum_l[AVG_BITS-1:0];
      count_nx = count_ff + 1'b1;

      avg_sel    = (state_ff == S_GO_GAIN) ? gain_ff : loss_ff;
      x_sel      = (state_ff == S_GO_GAIN) ? xg_ff : xl_ff;
      smooth_dvd = SMOOTH_BITS'(avg_sel * (p_ff - 1'b1))
                 + (SMOOTH_BITS'(x_sel) << FRACTION_BITS);
      scaled     = gain_ff * RSI_FULL;
      div_start  = (state_ff == S_GO_GAIN) || (state_ff == S_GO_LOSS)
                || (state_ff == S_GO_RSI);
      if (state_ff == S_GO_RSI) begin
         div_dvd = DVD_BITS'(scaled);
         div_dvs = {1'b0, gain_ff} + {1'b0, loss_ff};
      end else begin
         div_dvd = seed_ff ? (DVD_BITS'(avg_sel) << FRACTION_BITS) : DVD_BITS'(smooth_dvd);
         div_dvs = DVS_BITS'(p_ff);
      end
      quo_sat = (div_quo > DVD_BITS'(AVG_MAX)) ? AVG_MAX : div_quo[AVG_BITS-1:0];

      state_in     = state_ff;
      period_in    = (csr_valid && csr_ready) ? csr_data : period_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      gain_in      = gain_ff;
      loss_in      = loss_ff;
      count_in     = count_ff;
      xg_in        = xg_ff;
      xl_in        = xl_ff;
      seed_in      = seed_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               prev_in = req_word.price;
               p_in    = p_now;
               xg_in   = dg;
               xl_in   = dl;
               res_in  = '0;
               if (req_word.series_start) begin
                  gain_in  = '0;
                  loss_in  = '0;
                  count_in = '0;
                  state_in = S_RESULT;
               end else if (count_ff[COUNT_BITS-1] == 1'b0) begin
                  gain_in  = sat_g;
                  loss_in  = sat_l;
                  count_in = count_nx;
                  seed_in  = 1'b1;
                  if (count_nx >= COUNT_BITS'(p_now)) begin
                     count_in = SEEDED_MARK;
                     state_in = S_GO_GAIN;
                  end else begin
                     state_in = S_RESULT;
                  end
               end else begin
                  seed_in  = 1'b0;
                  state_in = S_GO_GAIN;
               end
            end
         end
         S_GO_GAIN:   state_in = S_WAIT_GAIN;
         S_WAIT_GAIN: begin
            if (div_done) begin
               gain_in  = quo_sat;
               state_in = S_GO_LOSS;
            end
         end
         S_GO_LOSS:   state_in = S_WAIT_LOSS;
         S_WAIT_LOSS: begin
            if (div_done) begin
               loss_in = quo_sat;
               if (quo_sat == '0) begin
                  res_in   = '{rsi_hundredths: RSI_FULL, ready_res: 1'b1};
                  state_in = S_RESULT;
               end else begin
                  state_in = S_GO_RSI;
               end
            end
         end
         S_GO_RSI:    state_in = S_WAIT_RSI;
         S_WAIT_RSI: begin
            if (div_done) begin
               res_in   = '{rsi_hundredths: div_quo[RSI_BITS-1:0], ready_res: 1'b1};
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= PERIOD_RESET;
         prev_ff      <= '0;
         gain_ff      <= '0;
         loss_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         prev_ff      <= prev_in;
         gain_ff      <= gain_in;
         loss_ff      <= loss_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff        <= p_in;
      xg_ff       <= xg_in;
      xl_ff       <= xl_in;
      seed_ff     <= seed_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WAIT_GAIN || state_ff == S_WAIT_LOSS
                    || state_ff == S_WAIT_RSI))
      else $error("divider finished outside a wait state");

   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.ready_res) |-> (rsp_word.rsi_hundredths == '0))
      else $error("result without ready flag carries a value");

   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.rsi_hundredths <= RSI_FULL))
      else $error("RSI above full scale");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.series_start) |=> (count_ff == '0 && gain_ff == '0))
      else $error("series start did not clear the state");
endmodule
`default_nettype wire

>>> design/wrsi_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module wrsi_divider import wrsi_pkg::*; #(
   parameter int DVD_BITS = 64,
   parameter int DVS_BITS = AVG_BITS + 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DVD_BITS-1:0] dividend,
   input  wire logic [DVS_BITS-1:0] divisor,
   output logic                     done,
   output logic [DVD_BITS-1:0]      quotient
);
   localparam int CNT_BITS = $clog2(DVD_BITS + 1);
   localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DVD_BITS - 1);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DVD_BITS-1:0] dvd_ff, dvd_in;
   logic [DVS_BITS-1:0] dvs_ff, dvs_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic                done_ff, done_in;
   logic [DVS_BITS:0]   rem_sh;
   logic                fits;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_BITS-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_BITS'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_BITS-1:0];
         dvd_in = {dvd_ff[DVD_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule
`default_nettype wire

>>> tb/wilder_rsi_tracker_unit_tb.sv
// Self-checking testbench for the Wilder RSI tracker with a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module wilder_rsi_tracker_unit_tb;
   import wrsi_pkg::*;

   localparam int FRAC = DEFAULT_FRACTION_BITS;
   localparam longint unsigned CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [PERIOD_BITS-1:0] csr_data = '0;

   logic [PERIOD_BITS-1:0] period_reg;
   logic [PRICE_BITS-1:0] last_price;
   logic [AVG_BITS-1:0] gain_avg, loss_avg;
   logic [COUNT_BITS-1:0] seed_count;
   rsp_word_type rsi_queue[$];
   int mismatches = 0;
   int results_seen = 0;
   int seeded_seen = 0;
   longint unsigned cycle_count = 0;

   wilder_rsi_tracker_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [AVG_BITS-1:0] clamp_avg(logic [127:0] v);
      logic [127:0] top;
      top = {{(128-AVG_BITS){1'b0}}, {AVG_BITS{1'b1}}};
      return (v > top) ? top[AVG_BITS-1:0] : v[AVG_BITS-1:0];
   endfunction

   function automatic rsp_word_type predict_rsi(req_word_type w);
      rsp_word_type r;
      logic [127:0] p, gain, loss, num;
      logic ready;
      r = '0;
      p = (period_reg < PERIOD_MIN) ? 128'(PERIOD_MIN) : 128'(period_reg);
      gain = 0;
      loss = 0;
      ready = 1'b0;
      if (w.series_start) begin
         last_price = w.price;
         gain_avg = '0;
         loss_avg = '0;
         seed_count = '0;
         return r;
      end
      if (w.price > last_price) gain = 128'(w.price - last_price);
      else loss = 128'(last_price - w.price);
      last_price = w.price;
      if (!seed_count[COUNT_BITS-1]) begin
         gain_avg = clamp_avg(128'(gain_avg) + gain);
         loss_avg = clamp_avg(128'(loss_avg) + loss);
         seed_count = seed_count + 1'b1;
         if (128'(seed_count) >= p) begin
            gain_avg = clamp_avg((128'(gain_avg) << FRAC) / p);
            loss_avg = clamp_avg((128'(loss_avg) << FRAC) / p);
            seed_count = 9'h100;
            ready = 1'b1;
         end
      end else begin
         gain_avg = clamp_avg((128'(gain_avg) * (p - 1) + (gain << FRAC)) / p);
         loss_avg = clamp_avg((128'(loss_avg) * (p - 1) + (loss << FRAC)) / p);
         ready = 1'b1;
      end
      if (ready) begin
         if (loss_avg == 0) r.rsi_hundredths = RSI_FULL;
         else begin
            num = 128'(gain_avg) * 10000 / (128'(gain_avg) + 128'(loss_avg));
            r.rsi_hundredths = num[RSI_BITS-1:0];
         end
         r.ready_res = 1'b1;
      end
      return r;
   endfunction

   // Receiver: random stall per word, compares each accepted word in order.
   initial begin : rsp_side
      int gap;
      rsp_word_type want;
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 4) == 0) gap = 0;
         rsp_stall = (gap != 0);
         repeat (gap) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         results_seen++;
         if (rsi_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected word: %h", rsp_word);
         end else begin
            want = rsi_queue.pop_front();
            if (rsp_word.ready_res) seeded_seen++;
            if (rsp_word.rsi_hundredths !== want.rsi_hundredths
                || rsp_word.ready_res !== want.ready_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected rsi %0d ready %0d, got rsi %0d ready %0d",
                           want.rsi_hundredths, want.ready_res,
                           rsp_word.rsi_hundredths, rsp_word.ready_res);
            end
         end
         @(negedge clock);
      end
   end

   task automatic send_price(logic [PRICE_BITS-1:0] price, logic start, bit use_gap = 1);
      req_word_type w;
      int gap;
      w.price = price;
      w.series_start = start;
      gap = use_gap ? $urandom_range(0, 15) : 0;
      if (use_gap && $urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      rsi_queue.push_back(predict_rsi(w));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain_results();
      while (rsi_queue.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic write_period(logic [PERIOD_BITS-1:0] value);
      drain_results();
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      period_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_extremes();
      write_period(8'd3);
      send_price(32'd0, 1'b1);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'd0, 1'b0);
      send_price(32'hFFFF_FFFF, 1'b0);
      send_price(32'h5555_5555, 1'b0);
      send_price(32'hAAAA_AAAA, 1'b0);
      send_price(32'd100, 1'b1);
      send_price(32'd150, 1'b0);
      send_price(32'd200, 1'b0);
      send_price(32'd250, 1'b0);
      send_price(32'd250, 1'b0);
      send_price(32'd240, 1'b0);
   endtask

   task automatic test_small_periods();
      write_period(8'd0);
      send_price(32'd10, 1'b1);
      send_price(32'd5, 1'b0);
      send_price(32'd7, 1'b0);
      write_period(8'd1);
      send_price(32'd3, 1'b0);
      send_price(32'd3, 1'b0);
   endtask

   task automatic test_period_change_while_seeding();
      write_period(8'd10);
      send_price(32'd1000, 1'b1);
      repeat (4) send_price($urandom, 1'b0);
      write_period(8'd2);
      send_price(32'd900, 1'b0);
      send_price(32'd1100, 1'b0);
   endtask

   task automatic test_random_series(int count, logic [PERIOD_BITS-1:0] period);
      logic [PRICE_BITS-1:0] price;
      write_period(period);
      price = $urandom;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 2) begin
            price = $urandom;
            send_price(price, 1'b1);
         end else begin
            case ($urandom_range(0, 9))
               0: price = $urandom;
               1: price = price;
               default: price = price + $urandom_range(0, 2000) - 1000;
            endcase
            send_price(price, 1'b0);
         end
      end
   endtask

   task automatic test_drain_pause();
      send_price(32'd5000, 1'b0);
      while (rsi_queue.size() != 0) @(negedge clock);
      repeat (20) send_price($urandom_range(4000, 6000), 1'b0, 0);
   endtask

   initial begin : stimulus
      period_reg = PERIOD_RESET;
      last_price = '0;
      gain_avg = '0;
      loss_avg = '0;
      seed_count = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      send_price(32'd50, 1'b0);
      send_price(32'd40, 1'b0);
      test_directed_extremes();
      test_small_periods();
      test_period_change_while_seeding();
      test_random_series(500, 8'd14);
      test_drain_pause();
      test_random_series(500, 8'd2);
      test_random_series(300, 8'd255);
      test_random_series(450, 8'($urandom_range(3, 40)));
      drain_results();
      $display("Checked %0d result words, %0d of them seeded, over periods 0 to 255.",
               results_seen, seeded_seen);
      if (mismatches == 0 && rsi_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d words missing.", mismatches, rsi_queue.size());
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
design/wrsi_pkg.sv
design/wrsi_divider.sv
design/wilder_rsi_tracker_unit.sv
tb/wilder_rsi_tracker_unit_tb.sv
